// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the top-level RTL file, the only one that carries assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define SRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/srs_pkg.sv -----
// ----------------------------------------------------------------------------
// srs_pkg
// Shared constants, codes and types of the sensor record statistics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srs_pkg;

    // Default widths of a sample and of a record index.
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COUNT_BITS_DEF  = 20;

    // Channels: X, Y, Z and temperature.
    localparam int NUM_CH  = 4;
    localparam int CH_BITS = 2;
    localparam logic [CH_BITS-1:0] CH_FIRST = 2'd0;
    localparam logic [CH_BITS-1:0] CH_LAST  = 2'd3;

    // Depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Result kinds.
    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Status of the iterative divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Width of one queued job: break flag, previous index, record total,
    // final flag and too-many flag.
    function automatic int job_width(input int count_bits);
        return 2 * count_bits + 5;
    endfunction

endpackage

// ----- rtl/srs_intf.sv -----
// ----------------------------------------------------------------------------
// srs_rec_if / srs_res_if
// Valid/ready channels for input records and for result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface srs_rec_if #(
    parameter int SAMPLE_BITS = srs_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = srs_pkg::COUNT_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [COUNT_BITS-1:0]         record_index;
    logic signed [SAMPLE_BITS-1:0] field_x;
    logic signed [SAMPLE_BITS-1:0] field_y;
    logic signed [SAMPLE_BITS-1:0] field_z;
    logic signed [SAMPLE_BITS-1:0] temperature;
    logic                          final_record;

    modport source (
        output valid, record_index, field_x, field_y, field_z, temperature, final_record,
        input  ready
    );
    modport sink (
        input  valid, record_index, field_x, field_y, field_z, temperature, final_record,
        output ready
    );
endinterface

interface srs_res_if #(
    parameter int SAMPLE_BITS = srs_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = srs_pkg::COUNT_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic                          index_break;
    logic signed [COUNT_BITS:0]    previous_index;
    logic [srs_pkg::CH_BITS-1:0]   channel;
    logic signed [SAMPLE_BITS-1:0] minimum;
    logic signed [SAMPLE_BITS-1:0] average;
    logic signed [SAMPLE_BITS-1:0] maximum;
    logic [COUNT_BITS:0]           record_total;
    logic                          too_many_records;
    logic                          last_of_run;

    modport source (
        output valid, kind, index_break, previous_index, channel, minimum, average,
               maximum, record_total, too_many_records, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, kind, index_break, previous_index, channel, minimum, average,
               maximum, record_total, too_many_records, last_of_run,
        output ready
    );
endinterface

// ----- rtl/sensor_record_statistics.sv -----
// Sensor record statistics: each accepted record yields one status result
// (index break, previous index, records counted so far), and a record
// marked final additionally yields four channel summaries (X, Y, Z,
// temperature) with minimum, mean truncated toward zero, maximum and a
// too-many-records flag, after which the run starts over. Records are
// taken one per cycle while the four-entry job queue has room. After a
// final record, input stalls until its summaries are out: each mean comes
// from the bit-serial divider that the four channels share.
// ----------------------------------------------------------------------------
// sensor_record_statistics
// Top level: front end with running statistics, job queue, back end with
// result sequencer and shared mean divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sensor_record_statistics #(
    parameter int SAMPLE_BITS = srs_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = srs_pkg::COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srs_rec_if.sink    i_rec,
    srs_res_if.source  o_res
);
    import srs_pkg::*;

    localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
    localparam int JOB_BITS = job_width(COUNT_BITS);

    logic                          q_push;
    logic                          q_pop;
    logic                          q_full;
    logic                          q_empty;
    logic [JOB_BITS-1:0]           q_in;
    logic [JOB_BITS-1:0]           q_out;

    logic                          snap_held;
    logic                          snap_free;
    logic signed [SAMPLE_BITS-1:0] snap_min [NUM_CH];
    logic signed [SAMPLE_BITS-1:0] snap_max [NUM_CH];
    logic signed [SUM_BITS-1:0]    snap_sum [NUM_CH];
    logic [COUNT_BITS:0]           snap_count;

    logic                          div_start;
    logic [SUM_BITS-1:0]           div_num;
    logic [COUNT_BITS:0]           div_den;
    logic [SUM_BITS-1:0]           div_quot;
    t_div_stat                     div_stat;

    // Front end: record intake and running statistics.
    srs_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec        (i_rec),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_job        (q_in),
        .o_snap_held  (snap_held),
        .i_snap_free  (snap_free),
        .o_snap_min   (snap_min),
        .o_snap_max   (snap_max),
        .o_snap_sum   (snap_sum),
        .o_snap_count (snap_count)
    );

    // Job queue between the two halves.
    srs_queue #(
        .WIDTH (JOB_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Mean divider, shared by the four channels.
    srs_divider #(
        .NUM_BITS (SUM_BITS),
        .DEN_BITS (COUNT_BITS + 1)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (div_quot),
        .o_stat  (div_stat)
    );

    // Back end: result sequencing and output register.
    srs_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_job        (q_out),
        .o_pop        (q_pop),
        .i_snap_min   (snap_min),
        .i_snap_max   (snap_max),
        .i_snap_sum   (snap_sum),
        .i_snap_count (snap_count),
        .o_snap_free  (snap_free),
        .o_div_start  (div_start),
        .o_div_num    (div_num),
        .o_div_den    (div_den),
        .i_div_quot   (div_quot),
        .i_div_stat   (div_stat),
        .o_res        (o_res)
    );

    // The queue is never written while full.
    `SRS_ASSERT_IMPLY(a_no_push_full, i_clk, i_rst_n, q_push, !q_full)
    // The snapshot is released only while it is held.
    `SRS_ASSERT_IMPLY(a_free_when_held, i_clk, i_rst_n, snap_free, snap_held)
    // A division is never started while one is running.
    `SRS_ASSERT_IMPLY(a_div_start_idle, i_clk, i_rst_n, div_start, !div_stat.busy)
    // Among summaries, only the temperature summary closes a run.
    `SRS_ASSERT_IMPLY(a_last_summary, i_clk, i_rst_n, o_res.valid && o_res.kind == KIND_SUMMARY, o_res.last_of_run == (o_res.channel == CH_LAST))

endmodule

// ----- rtl/srs_queue.sv -----
// ----------------------------------------------------------------------------
// srs_queue
// Small first-word-fall-through queue of jobs between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srs_queue #(
    parameter int WIDTH = 45,
    parameter int DEPTH = srs_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    import srs_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage is written only; it needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/srs_front.sv -----
// ----------------------------------------------------------------------------
// srs_front
// Accepts records, checks the index sequence, keeps the running count,
// minimum, maximum and sum, and queues one job per record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srs_front #(
    parameter int SAMPLE_BITS = srs_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = srs_pkg::COUNT_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    srs_rec_if.sink                                    i_rec,
    input  logic                                       i_q_full,
    output logic                                       o_push,
    output logic [srs_pkg::job_width(COUNT_BITS)-1:0]  o_job,
    output logic                                       o_snap_held,
    input  logic                                       i_snap_free,
    output logic signed [SAMPLE_BITS-1:0]              o_snap_min [srs_pkg::NUM_CH],
    output logic signed [SAMPLE_BITS-1:0]              o_snap_max [srs_pkg::NUM_CH],
    output logic signed [SAMPLE_BITS+COUNT_BITS-1:0]   o_snap_sum [srs_pkg::NUM_CH],
    output logic [COUNT_BITS:0]                        o_snap_count
);
    import srs_pkg::*;

    localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
    localparam logic [COUNT_BITS:0] COUNT_CAP = {1'b1, {COUNT_BITS{1'b0}}};

    typedef struct packed {
        logic                       brk;
        logic signed [COUNT_BITS:0] prev;
        logic [COUNT_BITS:0]        total;
        logic                       fin;
        logic                       many;
    } t_job;

    // Running state of the current run.
    logic [COUNT_BITS:0]           r_count, n_count;
    logic                          r_have_prev;
    logic [COUNT_BITS-1:0]         r_last;
    logic signed [SAMPLE_BITS-1:0] r_min [NUM_CH];
    logic signed [SAMPLE_BITS-1:0] r_max [NUM_CH];
    logic signed [SUM_BITS-1:0]    r_sum [NUM_CH];
    logic signed [SAMPLE_BITS-1:0] n_min [NUM_CH];
    logic signed [SAMPLE_BITS-1:0] n_max [NUM_CH];
    logic signed [SUM_BITS-1:0]    n_sum [NUM_CH];

    // Snapshot of a finished run, read by the back end.
    logic                          r_snap_held;
    logic signed [SAMPLE_BITS-1:0] r_snap_min [NUM_CH];
    logic signed [SAMPLE_BITS-1:0] r_snap_max [NUM_CH];
    logic signed [SUM_BITS-1:0]    r_snap_sum [NUM_CH];
    logic [COUNT_BITS:0]           r_snap_count;

    logic                          accept;
    logic                          seed;
    logic [COUNT_BITS:0]           idx_ext;
    logic [COUNT_BITS:0]           expect_idx;
    logic signed [SAMPLE_BITS-1:0] smp [NUM_CH];
    t_job                          job;

    // A record waits while the queue is full or a finished run is still read out.
    assign i_rec.ready = !i_q_full && !r_snap_held;
    assign accept      = i_rec.valid && i_rec.ready;

    assign smp[0] = i_rec.field_x;
    assign smp[1] = i_rec.field_y;
    assign smp[2] = i_rec.field_z;
    assign smp[3] = i_rec.temperature;

    // Count, extremes and sums after this record.
    always_comb begin
        seed    = (r_count == '0);
        n_count = (r_count == COUNT_CAP) ? r_count : r_count + 1'b1;
        for (int c = 0; c < NUM_CH; c++) begin
            n_min[c] = (seed || smp[c] < r_min[c]) ? smp[c] : r_min[c];
            n_max[c] = (seed || smp[c] > r_max[c]) ? smp[c] : r_max[c];
            n_sum[c] = r_sum[c] + SUM_BITS'(smp[c]);
        end
    end

    // Index sequence check and the job handed to the back end.
    always_comb begin
        idx_ext    = {1'b0, i_rec.record_index};
        expect_idx = r_have_prev ? {1'b0, r_last} + 1'b1 : '0;
        job.brk    = (idx_ext != expect_idx);
        job.prev   = r_have_prev ? signed'({1'b0, r_last}) : '1;
        job.total  = n_count;
        job.fin    = i_rec.final_record;
        job.many   = (n_count > idx_ext + 1'b1);
    end

    assign o_push = accept;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_have_prev <= 1'b0;
            r_snap_held <= 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_sum[c] <= '0;
            end
        end else begin
            if (accept) begin
                if (i_rec.final_record) begin
                    r_count     <= '0;
                    r_have_prev <= 1'b0;
                    for (int c = 0; c < NUM_CH; c++) begin
                        r_sum[c] <= '0;
                    end
                end else begin
                    r_count     <= n_count;
                    r_have_prev <= 1'b1;
                    for (int c = 0; c < NUM_CH; c++) begin
                        r_sum[c] <= n_sum[c];
                    end
                end
            end
            if (accept && i_rec.final_record) begin
                r_snap_held <= 1'b1;
            end else if (i_snap_free) begin
                r_snap_held <= 1'b0;
            end
        end
    end

    // Data registers: extremes are seeded by the first record of each run.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_last <= i_rec.record_index;
            for (int c = 0; c < NUM_CH; c++) begin
                r_min[c] <= n_min[c];
                r_max[c] <= n_max[c];
            end
            if (i_rec.final_record) begin
                r_snap_count <= n_count;
                for (int c = 0; c < NUM_CH; c++) begin
                    r_snap_min[c] <= n_min[c];
                    r_snap_max[c] <= n_max[c];
                    r_snap_sum[c] <= n_sum[c];
                end
            end
        end
    end

    assign o_snap_held  = r_snap_held;
    assign o_snap_min   = r_snap_min;
    assign o_snap_max   = r_snap_max;
    assign o_snap_sum   = r_snap_sum;
    assign o_snap_count = r_snap_count;

endmodule

// ----- rtl/srs_divider.sv -----
// ----------------------------------------------------------------------------
// srs_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srs_divider #(
    parameter int NUM_BITS = srs_pkg::SAMPLE_BITS_DEF + srs_pkg::COUNT_BITS_DEF,
    parameter int DEN_BITS = srs_pkg::COUNT_BITS_DEF + 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic [NUM_BITS-1:0] o_quot,
    output srs_pkg::t_div_stat  o_stat
);
    import srs_pkg::*;

    localparam int STEP_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0]  r_quot;
    logic [DEN_BITS-1:0]  r_rem;
    logic [DEN_BITS-1:0]  r_den;
    logic [STEP_BITS-1:0] r_step;
    logic                 r_busy;
    logic                 r_done;

    logic [DEN_BITS:0]    trial;
    logic [DEN_BITS:0]    diff;
    logic                 fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        trial = {r_rem, r_quot[NUM_BITS-1]};
        diff  = trial - {1'b0, r_den};
        fits  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= STEP_BITS'(NUM_BITS);
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (r_step == STEP_BITS'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // The quotient shifts in where the dividend shifts out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= {r_quot[NUM_BITS-2:0], fits};
            r_rem  <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        end
    end

    assign o_quot      = r_quot;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ----- rtl/srs_back.sv -----
// ----------------------------------------------------------------------------
// srs_back
// Takes jobs from the queue, sends the status result of each record and,
// after a final record, the four channel summaries with their means.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srs_back #(
    parameter int SAMPLE_BITS = srs_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = srs_pkg::COUNT_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_q_empty,
    input  logic [srs_pkg::job_width(COUNT_BITS)-1:0]  i_job,
    output logic                                       o_pop,
    input  logic signed [SAMPLE_BITS-1:0]              i_snap_min [srs_pkg::NUM_CH],
    input  logic signed [SAMPLE_BITS-1:0]              i_snap_max [srs_pkg::NUM_CH],
    input  logic signed [SAMPLE_BITS+COUNT_BITS-1:0]   i_snap_sum [srs_pkg::NUM_CH],
    input  logic [COUNT_BITS:0]                        i_snap_count,
    output logic                                       o_snap_free,
    output logic                                       o_div_start,
    output logic [SAMPLE_BITS+COUNT_BITS-1:0]          o_div_num,
    output logic [COUNT_BITS:0]                        o_div_den,
    input  logic [SAMPLE_BITS+COUNT_BITS-1:0]          i_div_quot,
    input  srs_pkg::t_div_stat                         i_div_stat,
    srs_res_if.source                                  o_res
);
    import srs_pkg::*;

    localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
    localparam logic [SUM_BITS-1:0] MAG_MIN =
        {{COUNT_BITS{1'b0}}, 1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SUM_BITS-1:0] MAG_MAX = MAG_MIN - 1'b1;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic ST_FETCH = 1'b0;
    localparam logic ST_DIV   = 1'b1;

    typedef struct packed {
        logic                       brk;
        logic signed [COUNT_BITS:0] prev;
        logic [COUNT_BITS:0]        total;
        logic                       fin;
        logic                       many;
    } t_job;

    logic               r_state, n_state;
    logic [CH_BITS-1:0] r_ch, n_ch;
    logic               r_div_go, n_div_go;
    logic               r_many;

    // Output register.
    logic                          r_out_valid;
    logic                          r_kind;
    logic                          r_brk;
    logic signed [COUNT_BITS:0]    r_prev;
    logic [CH_BITS-1:0]            r_chan;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic signed [SAMPLE_BITS-1:0] r_avg;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic [COUNT_BITS:0]           r_total;
    logic                          r_too_many;
    logic                          r_last;

    t_job                          job;
    logic                          out_free;
    logic                          load_status;
    logic                          load_summary;
    logic signed [SUM_BITS-1:0]    sum_sel;
    logic                          sum_neg;
    logic signed [SAMPLE_BITS-1:0] mean;

    assign job      = t_job'(i_job);
    assign out_free = !r_out_valid || o_res.ready;

    // Magnitude of the selected sum goes to the divider; the sign is put back after.
    always_comb begin
        sum_sel   = i_snap_sum[r_ch];
        sum_neg   = sum_sel[SUM_BITS-1];
        o_div_num = sum_neg ? unsigned'(-sum_sel) : unsigned'(sum_sel);
        o_div_den = i_snap_count;
    end

    // Signed mean, clamped to the sample range.
    always_comb begin
        if (sum_neg) begin
            mean = (i_div_quot > MAG_MIN) ? SAMPLE_MIN
                                          : -signed'(i_div_quot[SAMPLE_BITS-1:0]);
        end else begin
            mean = (i_div_quot > MAG_MAX) ? SAMPLE_MAX
                                          : signed'(i_div_quot[SAMPLE_BITS-1:0]);
        end
    end

    // Sequencer: one status per job, then four summaries after a final job.
    always_comb begin
        n_state      = r_state;
        n_ch         = r_ch;
        n_div_go     = r_div_go;
        o_pop        = 1'b0;
        o_div_start  = 1'b0;
        o_snap_free  = 1'b0;
        load_status  = 1'b0;
        load_summary = 1'b0;
        unique case (r_state)
            ST_FETCH: begin
                if (!i_q_empty && out_free) begin
                    o_pop       = 1'b1;
                    load_status = 1'b1;
                    if (job.fin) begin
                        n_state  = ST_DIV;
                        n_div_go = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (r_div_go) begin
                    o_div_start = 1'b1;
                    n_div_go    = 1'b0;
                end else if (i_div_stat.done && out_free) begin
                    load_summary = 1'b1;
                    if (r_ch == CH_LAST) begin
                        o_snap_free = 1'b1;
                        n_ch        = CH_FIRST;
                        n_state     = ST_FETCH;
                    end else begin
                        n_ch     = r_ch + 1'b1;
                        n_div_go = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_FETCH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FETCH;
            r_ch        <= CH_FIRST;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ch     <= n_ch;
            r_div_go <= n_div_go;
            if (load_status || load_summary) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; fields without meaning for a kind are zero, but a status result sets last_of_run when not final.
    always_ff @(posedge i_clk) begin
        if (load_status) begin
            r_many     <= job.many;
            r_kind     <= KIND_STATUS;
            r_brk      <= job.brk;
            r_prev     <= job.prev;
            r_chan     <= '0;
            r_min      <= '0;
            r_avg      <= '0;
            r_max      <= '0;
            r_total    <= job.total;
            r_too_many <= 1'b0;
            r_last     <= !job.fin;
        end else if (load_summary) begin
            r_kind     <= KIND_SUMMARY;
            r_brk      <= 1'b0;
            r_prev     <= '0;
            r_chan     <= r_ch;
            r_min      <= i_snap_min[r_ch];
            r_avg      <= mean;
            r_max      <= i_snap_max[r_ch];
            r_total    <= i_snap_count;
            r_too_many <= r_many;
            r_last     <= (r_ch == CH_LAST);
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.kind             = r_kind;
    assign o_res.index_break      = r_brk;
    assign o_res.previous_index   = r_prev;
    assign o_res.channel          = r_chan;
    assign o_res.minimum          = r_min;
    assign o_res.average          = r_avg;
    assign o_res.maximum          = r_max;
    assign o_res.record_total     = r_total;
    assign o_res.too_many_records = r_too_many;
    assign o_res.last_of_run      = r_last;

endmodule
